// File: rtl/lcdlmt_pkg.sv
// Package: shared types and constants for the LCD line and mode timing core.
`default_nettype none
package lcdlmt_pkg;

    // Fixed field widths
    localparam int DOTS_W = 9;
    localparam int LINE_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    // Timing defaults
    localparam int DOTS_PER_LINE_DEF = 456;
    localparam int VISIBLE_LINES_DEF = 144;
    localparam int LAST_LINE_DEF = 153;

    // Mode boundaries within a line
    localparam int OAM_END_DOT = 80;
    localparam int DRAW_END_DOT = 252;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LCD_ENABLE   = 3'd0,
        CFG_COMPARE_LINE = 3'd1,
        CFG_HBLANK_IE    = 3'd2,
        CFG_VBLANK_IE    = 3'd3,
        CFG_OAM_IE       = 3'd4,
        CFG_MATCH_IE     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              lcd_enable;
        logic [LINE_W-1:0] compare_line;
        logic              hblank_ie;
        logic              vblank_ie;
        logic              oam_ie;
        logic              match_ie;
    } t_cfg;

    // Line, held mode and coincidence flag; the dot counter travels on its own
    // since its width follows the line length.
    typedef struct packed {
        logic [LINE_W-1:0] line;
        t_mode             mode;
        logic              match;
    } t_state;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        t_mode             mode;
        logic              coincident;
        logic              vblank_irq;
        logic              stat_irq;
        logic              draw_line;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/lcd_line_mode_timing_core.sv
// Top level: LCD line and mode timing core with input stage, step logic and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_dots): each word carries the
//   number of dot clocks elapsed since the previous word (values of one line
//   length or more clamp to one dot short of a line). Output channel (o_out_valid / i_out_stall):
//   one result word per input word, in order: line, mode, coincidence flag and
//   pulses for vblank interrupt, status interrupt and line draw.
//   Configuration channel (i_cfg_valid / o_cfg_ready): writes one register per
//   handshake; index 0 display enable, 1 compare line, 2..5 status interrupt
//   enables for hblank, vblank, OAM scan and line match. Other indices drop.
//   o_cfg_ready is always high; write only while no word is in flight.
// Path: an accepted word loads the input register; the step logic then writes
//   the counters and the result register together, and o_out_valid rises with
//   the result.
// Throughput: one word per cycle while i_out_stall is low; the single add-compare step
//   on the dot counter and its feedback into the line counter set the cycle.
// Reset: counters, held mode, coincidence flag, valid flags and configuration clear; the
//   display starts off. Both pipeline registers empty.
// Stall: a stalled result holds in the result register; one more word still
//   enters the input register, then o_in_stall rises until the result moves.
`default_nettype none
module lcd_line_mode_timing_core #(
    parameter int DOTS_PER_LINE = lcdlmt_pkg::DOTS_PER_LINE_DEF,
    parameter int VISIBLE_LINES = lcdlmt_pkg::VISIBLE_LINES_DEF,
    parameter int LAST_LINE     = lcdlmt_pkg::LAST_LINE_DEF
) (
    input  wire  logic                                i_clk,
    input  wire  logic                                i_rst_n,
    // input words
    input  wire  logic                                i_in_valid,
    output logic                                      o_in_stall,
    input  wire  logic [lcdlmt_pkg::DOTS_W-1:0]       i_dots,
    // result words
    output logic                                      o_out_valid,
    input  wire  logic                                i_out_stall,
    output logic [lcdlmt_pkg::LINE_W-1:0]             o_line,
    output logic [1:0]                                o_mode,
    output logic                                      o_coincident,
    output logic                                      o_vblank_irq,
    output logic                                      o_stat_irq,
    output logic                                      o_draw_line,
    // configuration writes
    input  wire  logic                                i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire  logic [lcdlmt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  logic [lcdlmt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DW = $clog2(DOTS_PER_LINE);
    localparam int LINE_MAX = (LAST_LINE > VISIBLE_LINES) ? LAST_LINE : VISIBLE_LINES;

    // Configuration registers
    lcdlmt_pkg::t_cfg r_cfg;

    // Input stage
    logic                             r_in_valid;
    logic [lcdlmt_pkg::DOTS_W-1:0]    r_in_dots;

    // Timing state
    logic [DW-1:0]                    r_dot_count;
    lcdlmt_pkg::t_state               r_state;
    logic [DW-1:0]                    n_dot_count;
    lcdlmt_pkg::t_state               n_state;

    // Result register
    logic                             r_out_valid;
    lcdlmt_pkg::t_result              r_res;
    lcdlmt_pkg::t_result              n_res;

    logic                             w_out_free;
    logic                             w_step;

    // The result register can take a new word when empty or being drained
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; unknown indices drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lcdlmt_pkg::CFG_LCD_ENABLE:   r_cfg.lcd_enable   <= i_cfg_data[0];
                lcdlmt_pkg::CFG_COMPARE_LINE: r_cfg.compare_line <= i_cfg_data;
                lcdlmt_pkg::CFG_HBLANK_IE:    r_cfg.hblank_ie    <= i_cfg_data[0];
                lcdlmt_pkg::CFG_VBLANK_IE:    r_cfg.vblank_ie    <= i_cfg_data[0];
                lcdlmt_pkg::CFG_OAM_IE:       r_cfg.oam_ie       <= i_cfg_data[0];
                lcdlmt_pkg::CFG_MATCH_IE:     r_cfg.match_ie     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input stage: load when not stalled, otherwise hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_dots <= i_dots;
        end
    end

    lcdlmt_step #(
        .DOTS_PER_LINE (DOTS_PER_LINE),
        .VISIBLE_LINES (VISIBLE_LINES),
        .LAST_LINE     (LAST_LINE)
    ) u_step (
        .i_dots      (r_in_dots),
        .i_cfg       (r_cfg),
        .i_dot_count (r_dot_count),
        .i_state     (r_state),
        .o_dot_count (n_dot_count),
        .o_state     (n_state),
        .o_result    (n_res)
    );

    // Advance timing state together with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_count <= '0;
            r_state     <= '{line: '0, mode: lcdlmt_pkg::MODE_HBLANK, match: 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_dot_count <= n_dot_count;
                r_state     <= n_state;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line       = r_res.line;
    assign o_mode       = r_res.mode;
    assign o_coincident = r_res.coincident;
    assign o_vblank_irq = r_res.vblank_irq;
    assign o_stat_irq   = r_res.stat_irq;
    assign o_draw_line  = r_res.draw_line;

    // Dot counter stays inside one line
    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot_count < DW'(DOTS_PER_LINE - 1) || r_dot_count == DW'(DOTS_PER_LINE - 1))
        else $error("dot counter left the line");

    // Line counter never passes the last line
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line <= lcdlmt_pkg::LINE_W'(LINE_MAX))
        else $error("line counter out of range");

    // A draw pulse only comes with hblank
    a_draw_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_draw_line |-> o_mode == lcdlmt_pkg::MODE_HBLANK)
        else $error("draw pulse outside hblank");

    // A vblank pulse marks entry to the first blank line
    a_vbl_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_vblank_irq |->
            o_line == lcdlmt_pkg::LINE_W'(VISIBLE_LINES)
            && o_mode == lcdlmt_pkg::MODE_VBLANK)
        else $error("vblank pulse on wrong line");

    // Held mode in the state follows the last delivered result
    a_mode_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_state.mode == r_res.mode)
        else $error("held mode differs from result mode");

endmodule
`default_nettype wire

// File: rtl/lcdlmt_step.sv
// Step logic: advance dot and line counters by one word and derive mode and interrupts.
`default_nettype none
module lcdlmt_step #(
    parameter int DOTS_PER_LINE = lcdlmt_pkg::DOTS_PER_LINE_DEF,
    parameter int VISIBLE_LINES = lcdlmt_pkg::VISIBLE_LINES_DEF,
    parameter int LAST_LINE     = lcdlmt_pkg::LAST_LINE_DEF,
    localparam int DW = $clog2(DOTS_PER_LINE)
) (
    input  wire  logic [lcdlmt_pkg::DOTS_W-1:0] i_dots,
    input  wire  lcdlmt_pkg::t_cfg              i_cfg,
    input  wire  logic [DW-1:0]                 i_dot_count,
    input  wire  lcdlmt_pkg::t_state            i_state,
    output logic [DW-1:0]                       o_dot_count,
    output lcdlmt_pkg::t_state                  o_state,
    output lcdlmt_pkg::t_result                 o_result
);

    localparam int SW = DW + 1;
    localparam int LW = lcdlmt_pkg::LINE_W;

    logic [SW-1:0]   dots_ext;
    logic [SW-1:0]   dots_sat;
    logic [SW-1:0]   sum;
    logic            wrap;
    logic [DW-1:0]   dot_new;
    logic [LW:0]     line_inc;
    logic [LW:0]     line_wrapped;
    logic            vbl;
    logic [LW-1:0]   line_new;
    lcdlmt_pkg::t_mode mode_new;
    logic            mode_irq;
    logic            match;

    always_comb begin
        // Clamp to one dot short of a line so at most one boundary is crossed
        dots_ext = SW'(i_dots);
        dots_sat = (dots_ext > SW'(DOTS_PER_LINE - 1)) ? SW'(DOTS_PER_LINE - 1) : dots_ext;
        sum      = SW'(i_dot_count) + dots_sat;
        wrap     = (sum >= SW'(DOTS_PER_LINE));
        dot_new  = wrap ? DW'(sum - SW'(DOTS_PER_LINE)) : sum[DW-1:0];

        line_inc     = {1'b0, i_state.line} + (LW+1)'(1);
        vbl          = wrap && (line_inc == (LW+1)'(VISIBLE_LINES));
        line_wrapped = (!vbl && (line_inc > (LW+1)'(LAST_LINE))) ? '0 : line_inc;
        line_new     = wrap ? line_wrapped[LW-1:0] : i_state.line;

        if (line_new >= LW'(VISIBLE_LINES)) begin
            mode_new = lcdlmt_pkg::MODE_VBLANK;
        end else if (dot_new < DW'(lcdlmt_pkg::OAM_END_DOT)) begin
            mode_new = lcdlmt_pkg::MODE_OAM;
        end else if (dot_new < DW'(lcdlmt_pkg::DRAW_END_DOT)) begin
            mode_new = lcdlmt_pkg::MODE_DRAW;
        end else begin
            mode_new = lcdlmt_pkg::MODE_HBLANK;
        end

        mode_irq = 1'b0;
        if (mode_new != i_state.mode) begin
            unique case (mode_new)
                lcdlmt_pkg::MODE_HBLANK: mode_irq = i_cfg.hblank_ie;
                lcdlmt_pkg::MODE_VBLANK: mode_irq = i_cfg.vblank_ie;
                lcdlmt_pkg::MODE_OAM:    mode_irq = i_cfg.oam_ie;
                default:                 mode_irq = 1'b0;
            endcase
        end

        match = (line_new == i_cfg.compare_line);

        if (i_cfg.lcd_enable) begin
            o_dot_count         = dot_new;
            o_state.line        = line_new;
            o_state.mode        = mode_new;
            o_state.match       = match;
            o_result.line       = line_new;
            o_result.mode       = mode_new;
            o_result.coincident = match;
            o_result.vblank_irq = vbl;
            o_result.stat_irq   = mode_irq || (match && i_cfg.match_ie);
            o_result.draw_line  = (mode_new != i_state.mode)
                                  && (mode_new == lcdlmt_pkg::MODE_HBLANK);
        end else begin
            // Display off: clear counters, keep the coincidence flag
            o_dot_count         = '0;
            o_state.line        = '0;
            o_state.mode        = lcdlmt_pkg::MODE_HBLANK;
            o_state.match       = i_state.match;
            o_result.line       = '0;
            o_result.mode       = lcdlmt_pkg::MODE_HBLANK;
            o_result.coincident = i_state.match;
            o_result.vblank_irq = 1'b0;
            o_result.stat_irq   = 1'b0;
            o_result.draw_line  = 1'b0;
        end
    end

endmodule
`default_nettype wire
